// ----- hdl/lzwc_pkg.sv -----
// lzwc_pkg: shared types and constants of the LZW stream compressor.
// No dependencies.
package lzwc_pkg;
   localparam int MAX_CODE_BITS = 12;
   localparam int CODE_W = MAX_CODE_BITS;
   localparam int NEXT_W = MAX_CODE_BITS + 1;
   localparam int FIRST_FREE = 256;
   localparam int CODE_LIMIT = 1 << MAX_CODE_BITS;
   localparam int DICT_DEPTH = CODE_LIMIT - FIRST_FREE;
   localparam int ADDR_W = MAX_CODE_BITS;
   localparam int KEY_W = MAX_CODE_BITS + 8;
   localparam int WID_W = 5;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_word_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // latch input word
      logic start_first; // prefix takes byte
      logic probe_start; // begin scan at FIRST_FREE
      logic probe_step;  // advance scan
      logic take_hit;    // prefix takes hit code
      logic miss_insert; // insert pair, prefix takes byte
      logic emit_prefix; // load shifter with prefix code
      logic emit_pad;    // unused; S_PAD shows the partial byte
      logic shift_bit;   // move one code bit into accumulator
      logic clear;       // back to reset state
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic prefix_valid;
      logic last;
      logic scan_done;   // scan passed next_code
      logic scan_hit;    // registered entry matched
      logic bits_left;   // shifter still holds bits
      logic byte_ready;  // accumulator holds a full byte
      logic partial;     // bit_position != 7
   } sts_type;
endpackage

// ----- hdl/lzwc_datapath.sv -----
// lzwc_datapath: prefix, dictionary memory, scan counter, bit packer.
// Depends on lzwc_pkg.
module lzwc_datapath import lzwc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  req_word_type req_word,
   input  ctl_type      ctl,
   input  logic         out_take,
   output sts_type      sts,
   output logic [7:0]   acc_byte
);
   logic [7:0]        byte_ff;
   logic              last_ff;
   logic [CODE_W-1:0] prefix_ff;
   logic              pvalid_ff;
   logic [NEXT_W-1:0] next_ff;
   logic [NEXT_W-1:0] scan_ff;      // address presented to memory
   logic [NEXT_W-1:0] rd_code_ff;   // code of registered entry
   logic              rd_vld_ff;
   logic [KEY_W-1:0]  rd_data_ff;
   logic [KEY_W-1:0]  dict_mem [DICT_DEPTH];
   logic [CODE_W-1:0] sh_ff;
   logic [WID_W-1:0]  cnt_ff;
   logic [7:0]        acc_ff;
   logic [2:0]        pos_ff;
   logic              full_ff;
   logic [KEY_W-1:0]  key;
   logic [WID_W-1:0]  width;
   logic              cur_bit;
   logic [NEXT_W-1:0] rd_idx;
   logic [NEXT_W-1:0] wr_idx;

   assign key = {prefix_ff, byte_ff};

   always_comb begin
      width = WID_W'(MAX_CODE_BITS);
      for (int w = MAX_CODE_BITS - 1; w >= 9; w--)
         if (next_ff < NEXT_W'(1 << w)) width = WID_W'(w);
   end

   assign rd_idx = scan_ff - NEXT_W'(FIRST_FREE);
   assign wr_idx = next_ff - NEXT_W'(FIRST_FREE);
   assign cur_bit = sh_ff[cnt_ff[3:0] - 4'd1];

   always_ff @(posedge clock) begin
      rd_data_ff <= dict_mem[rd_idx[ADDR_W-1:0]];
      if (ctl.miss_insert && next_ff < NEXT_W'(CODE_LIMIT)) begin
         dict_mem[wr_idx[ADDR_W-1:0]] <= key;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         byte_ff <= req_word.in_byte;
         last_ff <= req_word.in_last;
      end
      if (ctl.emit_prefix) sh_ff <= prefix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         prefix_ff <= '0;
         pvalid_ff <= 1'b0;
         next_ff   <= NEXT_W'(FIRST_FREE);
         scan_ff   <= NEXT_W'(FIRST_FREE);
         rd_vld_ff <= 1'b0;
         rd_code_ff <= '0;
         cnt_ff    <= '0;
         acc_ff    <= '0;
         pos_ff    <= 3'd7;
         full_ff   <= 1'b0;
      end else begin
         rd_code_ff <= scan_ff;
         rd_vld_ff  <= ctl.probe_step && (scan_ff < next_ff);
         if (ctl.probe_start) begin
            scan_ff   <= NEXT_W'(FIRST_FREE);
         end else if (ctl.probe_step && scan_ff < next_ff) begin
            scan_ff <= scan_ff + NEXT_W'(1);
         end
         if (ctl.start_first) begin
            prefix_ff <= CODE_W'(byte_ff);
            pvalid_ff <= 1'b1;
         end
         if (ctl.take_hit) prefix_ff <= rd_code_ff[CODE_W-1:0];
         if (ctl.miss_insert) begin
            prefix_ff <= CODE_W'(byte_ff);
            if (next_ff < NEXT_W'(CODE_LIMIT)) next_ff <= next_ff + NEXT_W'(1);
         end
         if (ctl.emit_prefix) cnt_ff <= width;
         if (ctl.shift_bit) begin
            acc_ff[pos_ff] <= cur_bit;
            pos_ff <= pos_ff - 3'd1;
            cnt_ff <= cnt_ff - WID_W'(1);
            full_ff <= (pos_ff == 3'd0);
         end
         if (out_take) begin
            acc_ff  <= '0;
            pos_ff  <= 3'd7;
            full_ff <= 1'b0;
         end
      end
   end

   assign sts.prefix_valid = pvalid_ff;
   assign sts.last       = last_ff;
   assign sts.scan_done  = (scan_ff >= next_ff) && !rd_vld_ff;
   assign sts.scan_hit   = rd_vld_ff && (rd_data_ff == key);
   assign sts.bits_left  = (cnt_ff != '0);
   assign sts.byte_ready = full_ff;
   assign sts.partial    = (pos_ff != 3'd7);
   assign acc_byte       = acc_ff;
endmodule

// ----- hdl/lzwc_control.sv -----
// lzwc_control: sequencer for probe, insert and code emission.
// Depends on lzwc_pkg.
module lzwc_control import lzwc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output ctl_type ctl,
   output logic    out_valid,
   output logic    out_last,
   input  logic    out_take
);
   typedef enum logic [2:0] {
      S_IDLE, S_DISPATCH, S_PROBE, S_EMIT, S_WAIT, S_FINAL, S_PAD
   } state_type;

   state_type state_ff, state_in;
   logic      final_ff, final_in;

   assign req_stall = (state_ff != S_IDLE);
   assign out_valid = sts.byte_ready || (state_ff == S_PAD);
   assign out_last  = (state_ff == S_PAD) ||
                      (final_ff && state_ff == S_EMIT && !sts.bits_left);

   always_comb begin
      ctl = '0;
      state_in = state_ff;
      final_in = final_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!sts.prefix_valid) begin
               ctl.start_first = 1'b1;
               state_in = S_FINAL;
            end else begin
               ctl.probe_start = 1'b1;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (sts.scan_hit) begin
               ctl.take_hit = 1'b1;
               state_in = S_FINAL;
            end else if (sts.scan_done) begin
               ctl.emit_prefix = 1'b1;
               final_in = 1'b0;
               state_in = S_EMIT;
            end else begin
               ctl.probe_step = 1'b1;
            end
         end
         S_EMIT: begin
            if (sts.byte_ready) begin
               // hold until the full byte leaves
            end else if (sts.bits_left) begin
               ctl.shift_bit = 1'b1;
            end else if (final_ff) begin
               state_in = sts.partial ? S_PAD : S_WAIT;
               if (!sts.partial) ctl.clear = 1'b1;
            end else begin
               ctl.miss_insert = 1'b1;
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            if (sts.last) begin
               ctl.emit_prefix = 1'b1;
               final_in = 1'b1;
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PAD: begin
            if (out_take) begin
               ctl.clear = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_WAIT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         final_ff <= final_in;
      end
   end
endmodule

// ----- hdl/lzw_stream_compressor.sv -----
// lzw_stream_compressor: top level, LZW compressor with 9..12 bit codes.
// Depends on lzwc_pkg, lzwc_control, lzwc_datapath.
//
//  channel | direction | ports                          | word
//  req     | in        | req_valid req_stall req_word   | byte + last flag
//  rsp     | out       | rsp_valid rsp_stall rsp_word   | packed byte + last flag
//
// Steps: a word that only starts a prefix is accepted, dispatched and finished.
// A probe then scans the dictionary entries in order (up to
// next_code-256, at most 3840); the linear scan through the memory read port
// sets the pace. A miss shifts out each code bit, waits while each full output
// byte is shown, and then inserts. The last word does the same for its final
// code, then clears, or shows the padding byte until it is taken.
// Reset: synchronous, active high; the dictionary needs no clearing.
// Stalls: a full output byte holds the packer until rsp_stall drops.
module lzw_stream_compressor import lzwc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);
   ctl_type    ctl;
   sts_type    sts;
   logic [7:0] acc_byte;
   logic       out_last;
   logic       out_take;

   // a word leaves when shown and not stalled
   assign out_take = rsp_valid && !rsp_stall;

   lzwc_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .ctl       (ctl),
      .out_valid (rsp_valid),
      .out_last  (out_last),
      .out_take  (out_take)
   );

   lzwc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .ctl      (ctl),
      .out_take (out_take),
      .sts      (sts),
      .acc_byte (acc_byte)
   );

   assign rsp_word.out_byte = acc_byte;
   assign rsp_word.out_last = out_last;
endmodule
